// ===== rtl/wvpc_pkg.sv =====
// Shared types, constants and saturation helpers for the wheel velocity PID controller.
`default_nettype none

package wvpc_pkg;

    // Default number of wheels handled by the state table
    localparam int NUM_WHEELS_DEF = 4;

    // Item kinds
    localparam logic [1:0] FUNC_EDGE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_LOAD = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // Drive direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam int         APB_ADDR_W          = 5;
    localparam logic [2:0] REG_SPEED_SCALE     = 3'd0;
    localparam logic [2:0] REG_LPF_WEIGHT      = 3'd1;
    localparam logic [2:0] REG_COEF_NOW        = 3'd2;
    localparam logic [2:0] REG_COEF_PREV       = 3'd3;
    localparam logic [2:0] REG_COEF_PREV2      = 3'd4;
    localparam logic [2:0] REG_COUNT_POLARITY  = 3'd5;

    // Register reset values
    localparam logic [15:0]        RST_SPEED_SCALE    = 16'd2494;
    localparam logic [16:0]        RST_LPF_WEIGHT     = 17'd65536;
    localparam logic signed [31:0] RST_COEF_NOW       = 32'sd3277000;
    localparam logic signed [31:0] RST_COEF_PREV      = -32'sd5242729;
    localparam logic signed [31:0] RST_COEF_PREV2     = 32'sd1966080;
    localparam logic [3:0]         RST_COUNT_POLARITY = 4'd10;

    // Fixed-point constants
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;  // 1.0 in Q1.16
    localparam int          ROUND_HALF = 32768;      // half LSB before a 16-bit shift
    localparam int          CLAMP_Q8   = 65280;      // 255.0 in Q.8

    // Input transaction
    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         wheel;
        logic               dir_level;
        logic signed [23:0] setpoint;
        logic signed [15:0] pulse_value;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [1:0]         wheel_out;
        logic signed [31:0] position;
        logic signed [23:0] speed;
        logic [7:0]         duty;
        logic [1:0]         drive_dir;
    } t_out;

    // Configuration register values
    typedef struct packed {
        logic [15:0]        speed_scale;
        logic [16:0]        lpf_weight;
        logic signed [31:0] coef_now;
        logic signed [31:0] coef_prev;
        logic signed [31:0] coef_prev2;
        logic [3:0]         count_polarity;
    } t_cfg;

    // Per-wheel state entry
    typedef struct packed {
        logic [31:0]        pos;
        logic signed [15:0] win;
        logic signed [23:0] filt;
        logic signed [23:0] ep;
        logic signed [23:0] ep2;
        logic signed [47:0] last;
        logic [9:0]         hold;   // direction in 9..8, duty in 7..0
    } t_entry;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
        if (x > 64'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (x < -64'sd8388608) begin
            return 24'sh800000;
        end
        return x[23:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        if (x > 64'sh0000_7FFF_FFFF_FFFF) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (x < -64'sh0000_8000_0000_0000) begin
            return 48'sh8000_0000_0000;
        end
        return x[47:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wheel_velocity_pid_controller.sv =====
// Top level of the four-wheel incremental PID speed controller.
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid/o_in_stall   i_in_data   (t_in)
//  result    out        o_out_valid/i_out_stall o_out_data  (t_out)
//  config    in/out     APB psel/penable/pready paddr/pwdata/prdata
//
// Encoder edge, load, unused code and out-of-range wheel: read state, then result state.
// Control tick: six passes through the one shared 32x25 multiplier.
// One transaction is in flight at a time; the entry is read, updated and written back.
// The result register lets the next transaction be taken while a result is stalled.
// Synchronous reset clears the valid bits, so every wheel entry reads as zero.
`default_nettype none

module wheel_velocity_pid_controller #(
    parameter int NUM_WHEELS = wvpc_pkg::NUM_WHEELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire wvpc_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output wvpc_pkg::t_out                       o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wvpc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int AW = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

    wvpc_pkg::t_cfg   cfg;
    wvpc_pkg::t_entry mem_wr_data;
    wvpc_pkg::t_entry mem_rd_data;
    wvpc_pkg::t_out   res;
    logic             mem_rd_en;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_addr;
    logic             res_valid;
    logic             res_free;
    logic             r_out_valid;
    wvpc_pkg::t_out   r_out_data;

    wvpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wvpc_mem #(.NUM_WHEELS(NUM_WHEELS)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_wr_en   (mem_wr_en),
        .i_addr    (mem_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    wvpc_seq #(.NUM_WHEELS(NUM_WHEELS)) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_cfg         (cfg),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_addr    (mem_addr),
        .o_mem_wr_data (mem_wr_data),
        .i_mem_rd_data (mem_rd_data),
        .i_res_free    (res_free),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // Result register
    assign res_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/wvpc_cfg.sv =====
// APB configuration register file for the wheel velocity PID controller.
`default_nettype none

module wvpc_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wvpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    output wvpc_pkg::t_cfg                           o_cfg
);

    logic [2:0]         reg_idx;
    logic               wr_en;
    logic [15:0]        r_speed_scale;
    logic [16:0]        r_lpf_weight;
    logic signed [31:0] r_coef_now;
    logic signed [31:0] r_coef_prev;
    logic signed [31:0] r_coef_prev2;
    logic [3:0]         r_count_polarity;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale    <= wvpc_pkg::RST_SPEED_SCALE;
            r_lpf_weight     <= wvpc_pkg::RST_LPF_WEIGHT;
            r_coef_now       <= wvpc_pkg::RST_COEF_NOW;
            r_coef_prev      <= wvpc_pkg::RST_COEF_PREV;
            r_coef_prev2     <= wvpc_pkg::RST_COEF_PREV2;
            r_count_polarity <= wvpc_pkg::RST_COUNT_POLARITY;
        end else if (wr_en) begin
            unique case (reg_idx)
                wvpc_pkg::REG_SPEED_SCALE:    r_speed_scale    <= pwdata[15:0];
                wvpc_pkg::REG_LPF_WEIGHT:     r_lpf_weight     <= pwdata[16:0];
                wvpc_pkg::REG_COEF_NOW:       r_coef_now       <= pwdata;
                wvpc_pkg::REG_COEF_PREV:      r_coef_prev      <= pwdata;
                wvpc_pkg::REG_COEF_PREV2:     r_coef_prev2     <= pwdata;
                wvpc_pkg::REG_COUNT_POLARITY: r_count_polarity <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            wvpc_pkg::REG_SPEED_SCALE:    prdata = {16'd0, r_speed_scale};
            wvpc_pkg::REG_LPF_WEIGHT:     prdata = {15'd0, r_lpf_weight};
            wvpc_pkg::REG_COEF_NOW:       prdata = r_coef_now;
            wvpc_pkg::REG_COEF_PREV:      prdata = r_coef_prev;
            wvpc_pkg::REG_COEF_PREV2:     prdata = r_coef_prev2;
            wvpc_pkg::REG_COUNT_POLARITY: prdata = {28'd0, r_count_polarity};
            default:                      prdata = 32'd0;
        endcase
    end

    assign o_cfg.speed_scale    = r_speed_scale;
    assign o_cfg.lpf_weight     = r_lpf_weight;
    assign o_cfg.coef_now       = r_coef_now;
    assign o_cfg.coef_prev      = r_coef_prev;
    assign o_cfg.coef_prev2     = r_coef_prev2;
    assign o_cfg.count_polarity = r_count_polarity;

endmodule

`default_nettype wire

// ===== rtl/wvpc_mem.sv =====
// Per-wheel state table: synchronous memory with registered read and per-entry valid bits.
`default_nettype none

module wvpc_mem #(
    parameter  int NUM_WHEELS = wvpc_pkg::NUM_WHEELS_DEF,
    localparam int AW         = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_addr,
    input  wire wvpc_pkg::t_entry i_wr_data,
    output wvpc_pkg::t_entry      o_rd_data
);

    wvpc_pkg::t_entry        r_mem [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]   r_valid;
    wvpc_pkg::t_entry        r_rd_data;
    logic                    r_rd_ok;

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    // Valid bits: an entry never written reads as all zeros
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/wvpc_seq.sv =====
// Sequencer and shared-multiplier datapath: read, update and write back one wheel entry.
`default_nettype none

module wvpc_seq #(
    parameter  int NUM_WHEELS = wvpc_pkg::NUM_WHEELS_DEF,
    localparam int AW         = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire wvpc_pkg::t_in    i_in_data,
    input  wire wvpc_pkg::t_cfg   i_cfg,
    output logic                  o_mem_rd_en,
    output logic                  o_mem_wr_en,
    output logic [AW-1:0]         o_mem_addr,
    output wvpc_pkg::t_entry      o_mem_wr_data,
    input  wire wvpc_pkg::t_entry i_mem_rd_data,
    input  wire logic             i_res_free,
    output logic                  o_res_valid,
    output wvpc_pkg::t_out        o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_FILT  = 4'd2;
    localparam logic [3:0] S_RAW   = 4'd3;
    localparam logic [3:0] S_BLEND = 4'd4;
    localparam logic [3:0] S_ERR   = 4'd5;
    localparam logic [3:0] S_P0    = 4'd6;
    localparam logic [3:0] S_P1    = 4'd7;
    localparam logic [3:0] S_P2    = 4'd8;
    localparam logic [3:0] S_SUM   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_DRV   = 4'd11;
    localparam logic [3:0] S_RES   = 4'd12;

    logic [3:0]         r_state, n_state;
    wvpc_pkg::t_in      r_item;
    wvpc_pkg::t_entry   r_ent;
    wvpc_pkg::t_entry   rd_next;
    logic               r_ok;
    logic               r_wr;
    logic signed [56:0] r_p;
    logic signed [57:0] r_acc;
    logic signed [23:0] r_raw;
    logic signed [23:0] r_e;

    logic               accept;
    logic               in_range;
    logic               pol;
    logic               step_up;
    logic [16:0]        wt;
    logic [16:0]        inv_wt;
    logic signed [31:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [56:0] prod;
    logic signed [57:0] blend_sum;
    logic signed [24:0] err_diff;
    logic signed [57:0] round_sum;
    logic signed [41:0] d_q8;
    logic signed [48:0] out_sum;
    logic signed [16:0] clamped;
    logic [16:0]        mag;
    logic [1:0]         dir;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_range   = int'(r_item.wheel) < NUM_WHEELS;

    // Memory port: read on accept, write back while the result is handed over
    assign o_mem_rd_en   = accept;
    assign o_mem_wr_en   = (r_state == S_RES) && r_wr;
    assign o_mem_addr    = (r_state == S_IDLE) ? AW'(i_in_data.wheel) : AW'(r_item.wheel);
    assign o_mem_wr_data = r_ent;

    // Edge, load and tick updates of the entry just read
    assign pol     = i_cfg.count_polarity[r_item.wheel];
    assign step_up = (r_item.dir_level == pol);
    always_comb begin
        rd_next = i_mem_rd_data;
        case (r_item.func)
            wvpc_pkg::FUNC_EDGE: begin
                rd_next.pos = step_up ? i_mem_rd_data.pos + 32'd1 : i_mem_rd_data.pos - 32'd1;
                rd_next.win = step_up ? i_mem_rd_data.win + 16'sd1
                                      : i_mem_rd_data.win - 16'sd1;
            end
            wvpc_pkg::FUNC_TICK: rd_next.win = '0;
            wvpc_pkg::FUNC_LOAD: rd_next.win = r_item.pulse_value;
            default: ;
        endcase
    end

    // Low-pass weights
    assign wt     = (i_cfg.lpf_weight > wvpc_pkg::WEIGHT_ONE) ? wvpc_pkg::WEIGHT_ONE
                                                               : i_cfg.lpf_weight;
    assign inv_wt = wvpc_pkg::WEIGHT_ONE - wt;

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_READ: begin
                mul_a = 32'(i_mem_rd_data.win);
                mul_b = {9'd0, i_cfg.speed_scale};
            end
            S_FILT: begin
                mul_a = 32'(r_ent.filt);
                mul_b = {8'd0, inv_wt};
            end
            S_RAW: begin
                mul_a = 32'(r_raw);
                mul_b = {8'd0, wt};
            end
            S_P0: begin
                mul_a = i_cfg.coef_now;
                mul_b = 25'(r_e);
            end
            S_P1: begin
                mul_a = i_cfg.coef_prev;
                mul_b = 25'(r_ent.ep);
            end
            S_P2: begin
                mul_a = i_cfg.coef_prev2;
                mul_b = 25'(r_ent.ep2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Blend, error, PID rounding and output accumulation
    assign blend_sum = r_acc + 58'(r_p) + 58'(wvpc_pkg::ROUND_HALF);
    assign err_diff  = 25'(r_item.setpoint) - 25'(r_ent.filt);
    assign round_sum = r_acc + 58'(wvpc_pkg::ROUND_HALF);
    assign d_q8      = round_sum[57:16];
    assign out_sum   = 49'(r_ent.last) + 49'(d_q8);

    // Clamp to +-255.0 and split into duty and direction
    always_comb begin
        if (r_ent.last > 48'(wvpc_pkg::CLAMP_Q8)) begin
            clamped = 17'(wvpc_pkg::CLAMP_Q8);
        end else if (r_ent.last < -48'(wvpc_pkg::CLAMP_Q8)) begin
            clamped = -17'(wvpc_pkg::CLAMP_Q8);
        end else begin
            clamped = r_ent.last[16:0];
        end
        mag = clamped[16] ? 17'(-clamped) : 17'(clamped);
        if (clamped > 17'sd0) begin
            dir = wvpc_pkg::DIR_FWD;
        end else if (clamped < 17'sd0) begin
            dir = wvpc_pkg::DIR_REV;
        end else begin
            dir = wvpc_pkg::DIR_STOP;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_READ;
            S_READ:  n_state = (in_range && r_item.func == wvpc_pkg::FUNC_TICK) ? S_FILT : S_RES;
            S_FILT:  n_state = S_RAW;
            S_RAW:   n_state = S_BLEND;
            S_BLEND: n_state = S_ERR;
            S_ERR:   n_state = S_P0;
            S_P0:    n_state = S_P1;
            S_P1:    n_state = S_P2;
            S_P2:    n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT:   n_state = S_DRV;
            S_DRV:   n_state = S_RES;
            S_RES:   if (i_res_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (accept) r_item <= i_in_data;
            S_READ: begin
                r_ent <= rd_next;
                r_p   <= prod;
                r_ok  <= in_range;
                r_wr  <= in_range && (r_item.func != wvpc_pkg::FUNC_NONE);
            end
            S_FILT: begin
                r_raw <= wvpc_pkg::sat24(64'(r_p));
                r_p   <= prod;
            end
            S_RAW: begin
                r_acc <= 58'(r_p);
                r_p   <= prod;
            end
            S_BLEND: r_ent.filt <= blend_sum[39:16];
            S_ERR:   r_e <= wvpc_pkg::sat24(64'(err_diff));
            S_P0:    r_p <= prod;
            S_P1: begin
                r_acc <= 58'(r_p);
                r_p   <= prod;
            end
            S_P2: begin
                r_acc <= r_acc + 58'(r_p);
                r_p   <= prod;
            end
            S_SUM:   r_acc <= r_acc + 58'(r_p);
            S_OUT:   r_ent.last <= wvpc_pkg::sat48(64'(out_sum));
            S_DRV: begin
                r_ent.hold <= {dir, mag[15:8]};
                r_ent.ep2  <= r_ent.ep;
                r_ent.ep   <= r_e;
            end
            default: ;
        endcase
    end

    // Result
    assign o_res_valid       = (r_state == S_RES) && i_res_free;
    assign o_res.wheel_out   = r_item.wheel;
    assign o_res.position    = r_ok ? r_ent.pos : '0;
    assign o_res.speed       = r_ok ? r_ent.filt : '0;
    assign o_res.duty        = r_ok ? r_ent.hold[7:0] : '0;
    assign o_res.drive_dir   = r_ok ? r_ent.hold[9:8] : wvpc_pkg::DIR_STOP;

endmodule

`default_nettype wire

// ===== rtl/wvpc_chk.sv =====
// Port-level checker for the wheel velocity PID controller, bound to the top level.
`default_nettype none

module wvpc_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_stall,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_stall,
    input wire wvpc_pkg::t_out                  o_out_data
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Transactions taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (in_acc && !out_acc) begin
            r_pend <= r_pend + 2'd1;
        end else if (!in_acc && out_acc) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // One transaction in the core at a time: busy right after taking one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while previous transaction still in progress");

    // A result always belongs to a transaction taken earlier
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 2'd0)
        else $error("result presented with no pending transaction");

    // At most one in the core plus one in the result register
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two transactions outstanding");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

endmodule

bind wheel_velocity_pid_controller wvpc_chk u_wvpc_chk (.*);

`default_nettype wire

// ===== tb/sv/tb_wheel_velocity_pid_controller.sv =====
// Self-checking testbench for the wheel velocity PID controller: directed rows, random traffic.
`timescale 1ns / 1ps

module tb_wheel_velocity_pid_controller;

    localparam int NUM_WHEELS   = wvpc_pkg::NUM_WHEELS_DEF;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RAND_PER_SET = 75;
    localparam int REPORT_MAX   = 10;
    localparam longint LAST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint LAST_MIN = -LAST_MAX - 1;
    localparam longint SPD_MAX  = 64'sd8388607;
    localparam longint SPD_MIN  = -SPD_MAX - 1;

    // Directed table row: either one input transaction or one register write
    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        logic [2:0]      reg_idx;
        logic [31:0]     reg_val;
        wvpc_pkg::t_in   item;
        bit              typed;
        wvpc_pkg::t_out  res;
    } t_dir_row;

    // DUT connections
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    wvpc_pkg::t_in                   i_in_data;
    logic                            o_out_valid;
    logic                            i_out_stall;
    wvpc_pkg::t_out                  o_out_data;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [wvpc_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    // Shadow of the controller: registers and per-wheel table
    wvpc_pkg::t_cfg   cfg_m;
    wvpc_pkg::t_entry wheel_st [NUM_WHEELS];

    // Results still owed by the controller, oldest first
    wvpc_pkg::t_out   owed_q [$];
    wvpc_pkg::t_out   want;
    bit               res_bad;

    int     src_idle_pct;
    int     stall_pct;
    int     idle_cycles;
    int     n_bad;
    int     n_items;
    int     n_ticks;
    int     n_results;
    int     n_settings;

    t_dir_row dir_rows [$];

    wheel_velocity_pid_controller #(
        .NUM_WHEELS (NUM_WHEELS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Advance the shadow state by one input transaction and return the result it yields
    function automatic wvpc_pkg::t_out predict_wheel(input wvpc_pkg::t_in it);
        wvpc_pkg::t_out r;
        logic [1:0]     w;
        longint         cnt, scale, raw, wt, fprev, filt, sp, err, ep, ep2, dlt, acc, mag;
        longint         cn, cp, cp2, lastv;
        logic [1:0]     dir;
        w = it.wheel;
        r = '0;
        r.wheel_out = w;
        // wheel beyond the table: state untouched, zero result
        if (int'(w) >= NUM_WHEELS) return r;
        case (it.func)
            wvpc_pkg::FUNC_EDGE: begin
                if (it.dir_level == cfg_m.count_polarity[w]) begin
                    wheel_st[w].pos = wheel_st[w].pos + 32'd1;
                    wheel_st[w].win = wheel_st[w].win + 16'sd1;
                end else begin
                    wheel_st[w].pos = wheel_st[w].pos - 32'd1;
                    wheel_st[w].win = wheel_st[w].win - 16'sd1;
                end
            end
            wvpc_pkg::FUNC_TICK: begin
                cnt   = $signed(wheel_st[w].win);
                scale = cfg_m.speed_scale;
                raw   = clip(cnt * scale, SPD_MIN, SPD_MAX);
                wt    = cfg_m.lpf_weight;
                if (wt > 65536) wt = 65536;
                fprev = $signed(wheel_st[w].filt);
                // low-pass blend, rounded, floor shift
                filt  = (raw * wt + fprev * (65536 - wt) + 32768) >>> 16;
                sp    = $signed(it.setpoint);
                err   = clip(sp - filt, SPD_MIN, SPD_MAX);
                ep    = $signed(wheel_st[w].ep);
                ep2   = $signed(wheel_st[w].ep2);
                cn    = $signed(cfg_m.coef_now);
                cp    = $signed(cfg_m.coef_prev);
                cp2   = $signed(cfg_m.coef_prev2);
                // incremental step in Q.24, back to Q.8
                dlt   = cn * err + cp * ep + cp2 * ep2;
                dlt   = (dlt + 32768) >>> 16;
                lastv = $signed(wheel_st[w].last);
                acc   = clip(lastv + dlt, LAST_MIN, LAST_MAX);
                wheel_st[w].last = acc[47:0];
                wheel_st[w].ep2  = wheel_st[w].ep;
                wheel_st[w].ep   = err[23:0];
                wheel_st[w].filt = filt[23:0];
                wheel_st[w].win  = '0;
                // drive: clamp to +-255.0, sign gives direction
                acc = clip(acc, -wvpc_pkg::CLAMP_Q8, wvpc_pkg::CLAMP_Q8);
                dir = (acc > 0) ? wvpc_pkg::DIR_FWD
                                : ((acc < 0) ? wvpc_pkg::DIR_REV : wvpc_pkg::DIR_STOP);
                mag = (acc < 0) ? -acc : acc;
                wheel_st[w].hold = {dir, mag[15:8]};
            end
            wvpc_pkg::FUNC_LOAD: wheel_st[w].win = it.pulse_value;
            wvpc_pkg::FUNC_NONE: ;
            default: ;
        endcase
        r.position  = wheel_st[w].pos;
        r.speed     = wheel_st[w].filt;
        r.duty      = wheel_st[w].hold[7:0];
        r.drive_dir = wheel_st[w].hold[9:8];
        return r;
    endfunction

    function automatic wvpc_pkg::t_out res_of(input logic [1:0] w, input int pos, input int spd,
                                              input logic [7:0] duty, input logic [1:0] dir);
        wvpc_pkg::t_out r;
        r.wheel_out = w;
        r.position  = pos;
        r.speed     = spd[23:0];
        r.duty      = duty;
        r.drive_dir = dir;
        return r;
    endfunction

    function automatic t_dir_row mk_item(input logic [1:0] f, input logic [1:0] w,
                                         input logic lv, input int sp, input int pv);
        t_dir_row r;
        r.kind             = ROW_ITEM;
        r.reg_idx          = '0;
        r.reg_val          = '0;
        r.typed            = 1'b0;
        r.res              = '0;
        r.item.func        = f;
        r.item.wheel       = w;
        r.item.dir_level   = lv;
        r.item.setpoint    = sp[23:0];
        r.item.pulse_value = pv[15:0];
        return r;
    endfunction

    function automatic t_dir_row mk_chk(input logic [1:0] f, input logic [1:0] w,
                                        input logic lv, input int sp, input int pv,
                                        input wvpc_pkg::t_out res);
        t_dir_row r;
        r       = mk_item(f, w, lv, sp, pv);
        r.typed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    function automatic t_dir_row mk_reg(input logic [2:0] idx, input logic [31:0] val);
        t_dir_row r;
        r         = mk_item(wvpc_pkg::FUNC_NONE, 2'd0, 1'b0, 0, 0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // One input transaction, with random idle cycles in front of it
    task automatic send_item(input wvpc_pkg::t_in it, input bit typed,
                             input wvpc_pkg::t_out typed_res);
        wvpc_pkg::t_out guess;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_data  = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        guess = predict_wheel(it);
        owed_q.push_back(typed ? typed_res : guess);
        n_items++;
        if (it.func == wvpc_pkg::FUNC_TICK) n_ticks++;
    endtask

    // Hold the input side idle until every owed result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (owed_q.size() != 0) @(posedge i_clk);
    endtask

    // Register write followed by a read-back check
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] reg_want;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            wvpc_pkg::REG_SPEED_SCALE: begin
                cfg_m.speed_scale = val[15:0];
                reg_want = {16'd0, val[15:0]};
            end
            wvpc_pkg::REG_LPF_WEIGHT: begin
                cfg_m.lpf_weight = val[16:0];
                reg_want = {15'd0, val[16:0]};
            end
            wvpc_pkg::REG_COEF_NOW: begin
                cfg_m.coef_now = val;
                reg_want = val;
            end
            wvpc_pkg::REG_COEF_PREV: begin
                cfg_m.coef_prev = val;
                reg_want = val;
            end
            wvpc_pkg::REG_COEF_PREV2: begin
                cfg_m.coef_prev2 = val;
                reg_want = val;
            end
            wvpc_pkg::REG_COUNT_POLARITY: begin
                cfg_m.count_polarity = val[3:0];
                reg_want = {28'd0, val[3:0]};
            end
            default: reg_want = '0;
        endcase
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== reg_want) begin
            n_bad++;
            if (n_bad <= REPORT_MAX)
                $display("[%0t] register %0d read back 0x%08h, expected 0x%08h",
                         $time, idx, rd, reg_want);
        end
    endtask

    // Result side: random stall, driven at the falling edge
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (owed_q.size() == 0) begin
                n_bad++;
                if (n_bad <= REPORT_MAX)
                    $display("[%0t] result with nothing owed: wheel %0d pos %0d speed %0d",
                             $time, o_out_data.wheel_out, $signed(o_out_data.position),
                             $signed(o_out_data.speed));
            end else begin
                want    = owed_q.pop_front();
                res_bad = (o_out_data.wheel_out !== want.wheel_out)
                       || (o_out_data.position  !== want.position)
                       || (o_out_data.speed     !== want.speed)
                       || (o_out_data.duty      !== want.duty)
                       || (o_out_data.drive_dir !== want.drive_dir);
                if (res_bad) begin
                    n_bad++;
                    if (n_bad <= REPORT_MAX) begin
                        $display("[%0t] result mismatch: expected wheel %0d pos %0d %s",
                                 $time, want.wheel_out, $signed(want.position),
                                 $sformatf("speed %0d duty %0d dir %0d",
                                           $signed(want.speed), want.duty,
                                           want.drive_dir));
                        $display("[%0t]   got wheel %0d pos %0d speed %0d duty %0d dir %0d",
                                 $time, o_out_data.wheel_out, $signed(o_out_data.position),
                                 $signed(o_out_data.speed), o_out_data.duty,
                                 o_out_data.drive_dir);
                    end
                end
            end
        end
    end

    // Cycles without any handshake or register access
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("wheel_velocity_pid_controller verification failed");
        $finish;
    end

    // Stimulus
    initial begin : stim
        wvpc_pkg::t_in it;
        int            sel;
        int            k;
        bit [3:0]      trend;
        logic [15:0]   s_scale;
        logic [16:0]   s_lpf;
        logic [31:0]   s_cn, s_cp, s_cp2;
        logic [3:0]    s_pol;

        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        src_idle_pct = 0;
        stall_pct    = 0;
        idle_cycles  = 0;
        n_bad        = 0;
        n_items      = 0;
        n_ticks      = 0;
        n_results    = 0;
        n_settings   = 1;
        trend        = 4'b0101;

        cfg_m.speed_scale    = wvpc_pkg::RST_SPEED_SCALE;
        cfg_m.lpf_weight     = wvpc_pkg::RST_LPF_WEIGHT;
        cfg_m.coef_now       = wvpc_pkg::RST_COEF_NOW;
        cfg_m.coef_prev      = wvpc_pkg::RST_COEF_PREV;
        cfg_m.coef_prev2     = wvpc_pkg::RST_COEF_PREV2;
        cfg_m.count_polarity = wvpc_pkg::RST_COUNT_POLARITY;
        foreach (wheel_st[i]) wheel_st[i] = '0;

        // Directed rows; reset polarity has wheels 1 and 3 counting up on a high level
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_EDGE, 2'd0, 1'b0, 0, 0,
                                  res_of(2'd0, 1, 0, 8'd0, wvpc_pkg::DIR_STOP)));
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_EDGE, 2'd0, 1'b1, 0, 0,
                                  res_of(2'd0, 0, 0, 8'd0, wvpc_pkg::DIR_STOP)));
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_EDGE, 2'd1, 1'b0, 0, 0,
                                  res_of(2'd1, -1, 0, 8'd0, wvpc_pkg::DIR_STOP)));
        // unused code reports stored state only
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_NONE, 2'd2, 1'b1, 8388607, -32768,
                                  res_of(2'd2, 0, 0, 8'd0, wvpc_pkg::DIR_STOP)));
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_LOAD, 2'd3, 1'b0, 0, 32767,
                                  res_of(2'd3, 0, 0, 8'd0, wvpc_pkg::DIR_STOP)));
        // window count wraps to the most negative value
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_EDGE, 2'd3, 1'b1, 0, 0,
                                  res_of(2'd3, 1, 0, 8'd0, wvpc_pkg::DIR_STOP)));
        // speed saturates low, drive saturates forward
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_TICK, 2'd3, 1'b0, 8388607, 0,
                                  res_of(2'd3, 1, -8388608, 8'd255, wvpc_pkg::DIR_FWD)));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_TICK, 2'd3, 1'b1, -8388608, 0));
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_TICK, 2'd0, 1'b0, 0, 0,
                                  res_of(2'd0, 0, 0, 8'd0, wvpc_pkg::DIR_STOP)));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_LOAD, 2'd2, 1'b0, 0, -32768));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_TICK, 2'd2, 1'b0, 0, 0));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_EDGE, 2'd2, 1'b1, 0, 0));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_EDGE, 2'd1, 1'b1, 0, 0));
        // unity proportional gain: small outputs give direction with zero duty
        dir_rows.push_back(mk_reg(wvpc_pkg::REG_COEF_NOW, 32'd65536));
        dir_rows.push_back(mk_reg(wvpc_pkg::REG_COEF_PREV, 32'd0));
        dir_rows.push_back(mk_reg(wvpc_pkg::REG_COEF_PREV2, 32'd0));
        dir_rows.push_back(mk_reg(wvpc_pkg::REG_SPEED_SCALE, 32'd256));
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_TICK, 2'd1, 1'b0, 100, 0,
                                  res_of(2'd1, 0, 0, 8'd0, wvpc_pkg::DIR_FWD)));
        dir_rows.push_back(mk_chk(wvpc_pkg::FUNC_TICK, 2'd1, 1'b0, -200, 0,
                                  res_of(2'd1, 0, 0, 8'd0, wvpc_pkg::DIR_REV)));
        // filter weight above one saturates, zero weight holds the old speed
        dir_rows.push_back(mk_reg(wvpc_pkg::REG_LPF_WEIGHT, 32'h0001_FFFF));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_LOAD, 2'd0, 1'b0, 0, 1000));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_TICK, 2'd0, 1'b0, 12800, 0));
        dir_rows.push_back(mk_reg(wvpc_pkg::REG_LPF_WEIGHT, 32'd0));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_TICK, 2'd0, 1'b0, -12800, 0));
        dir_rows.push_back(mk_reg(wvpc_pkg::REG_COUNT_POLARITY, 32'd5));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_EDGE, 2'd0, 1'b1, 0, 0));
        dir_rows.push_back(mk_item(wvpc_pkg::FUNC_EDGE, 2'd1, 1'b1, 0, 0));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_drained();
                apb_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        // Random traffic: four handshake mixes, two register settings each
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  stall_pct = 0;  end
                1: begin src_idle_pct = 73; stall_pct = 0;  end
                2: begin src_idle_pct = 0;  stall_pct = 73; end
                default: begin src_idle_pct = 35; stall_pct = 35; end
            endcase
            for (int hf = 0; hf < 2; hf++) begin
                k = 2 * ph + hf;
                if (k == 0) begin
                    s_scale = wvpc_pkg::RST_SPEED_SCALE;
                    s_lpf   = wvpc_pkg::RST_LPF_WEIGHT;
                    s_cn    = wvpc_pkg::RST_COEF_NOW;
                    s_cp    = wvpc_pkg::RST_COEF_PREV;
                    s_cp2   = wvpc_pkg::RST_COEF_PREV2;
                    s_pol   = wvpc_pkg::RST_COUNT_POLARITY;
                end else if (k == 1) begin
                    s_scale = 16'hFFFF;
                    s_lpf   = 17'h1FFFF;
                    s_cn    = 32'h7FFF_FFFF;
                    s_cp    = 32'h8000_0000;
                    s_cp2   = 32'h7FFF_FFFF;
                    s_pol   = 4'hF;
                end else if (k == 2) begin
                    s_scale = 16'h0000;
                    s_lpf   = wvpc_pkg::WEIGHT_ONE;
                    s_cn    = 32'h8000_0000;
                    s_cp    = 32'h7FFF_FFFF;
                    s_cp2   = 32'h8000_0000;
                    s_pol   = 4'h0;
                end else if (k % 2 == 1) begin
                    // anything the registers hold
                    s_scale = 16'($urandom);
                    s_lpf   = 17'($urandom_range(131071));
                    s_cn    = $urandom;
                    s_cp    = $urandom;
                    s_cp2   = $urandom;
                    s_pol   = 4'($urandom);
                end else begin
                    // moderate gains so the drive spends time inside its clamp
                    s_scale = 16'($urandom_range(4096, 64));
                    s_lpf   = 17'($urandom_range(65536, 8192));
                    s_cn    = int'($urandom_range(1 << 19)) - (1 << 18);
                    s_cp    = int'($urandom_range(1 << 19)) - (1 << 18);
                    s_cp2   = int'($urandom_range(1 << 19)) - (1 << 18);
                    s_pol   = 4'($urandom);
                end
                wait_drained();
                apb_write(wvpc_pkg::REG_SPEED_SCALE, {16'd0, s_scale});
                apb_write(wvpc_pkg::REG_LPF_WEIGHT, {15'd0, s_lpf});
                apb_write(wvpc_pkg::REG_COEF_NOW, s_cn);
                apb_write(wvpc_pkg::REG_COEF_PREV, s_cp);
                apb_write(wvpc_pkg::REG_COEF_PREV2, s_cp2);
                apb_write(wvpc_pkg::REG_COUNT_POLARITY, {28'd0, s_pol});
                n_settings++;

                repeat (RAND_PER_SET) begin
                    if ($urandom_range(99) < 2) wait_drained();
                    it.wheel = 2'($urandom_range(3));
                    if ($urandom_range(99) < 5) trend[it.wheel] = ~trend[it.wheel];
                    // mostly edge bursts closed by ticks, some loads and unused codes
                    sel = $urandom_range(99);
                    if (sel < 62)
                        it.func = wvpc_pkg::FUNC_EDGE;
                    else if (sel < 84)
                        it.func = wvpc_pkg::FUNC_TICK;
                    else if (sel < 94)
                        it.func = wvpc_pkg::FUNC_LOAD;
                    else
                        it.func = wvpc_pkg::FUNC_NONE;
                    it.dir_level = ($urandom_range(99) < 85) ? trend[it.wheel]
                                                             : ~trend[it.wheel];
                    if ($urandom_range(9) == 0)
                        it.setpoint = 24'($urandom);
                    else
                        it.setpoint = 24'(int'($urandom_range(40000)) - 20000);
                    if ($urandom_range(3) == 0)
                        it.pulse_value = 16'($urandom);
                    else
                        it.pulse_value = 16'(int'($urandom_range(200)) - 100);
                    send_item(it, 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (owed_q.size() != 0) begin
            n_bad += owed_q.size();
            $display("%0d results never arrived", owed_q.size());
        end

        $display("Covered %0d input transactions (%0d control ticks) over %0d register settings",
                 n_items, n_ticks, n_settings);
        $display("and four idle/stall mixes; %0d results checked, %0d failures.",
                 n_results, n_bad);
        if (n_bad == 0)
            $display("wheel_velocity_pid_controller verification clean");
        else
            $display("wheel_velocity_pid_controller verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wvpc_pkg.sv
rtl/wvpc_cfg.sv
rtl/wvpc_mem.sv
rtl/wvpc_seq.sv
rtl/wheel_velocity_pid_controller.sv
rtl/wvpc_chk.sv
tb/sv/tb_wheel_velocity_pid_controller.sv
